/* rtl/ardt_pkg.sv */
// Shared types and codes for the answered-request deduplication table.
`timescale 1ns / 1ps
`default_nettype none

package ardt_pkg;

    localparam int ADDR_HALF_W = 64;
    localparam int PORT_W      = 16;
    localparam int MSG_ID_W    = 16;
    localparam int LIFE_W      = 16;
    localparam int OP_W        = 2;
    localparam int OUTCOME_W   = 2;
    localparam int SLOT_W      = 6;
    localparam int KEY_W       = 2 * ADDR_HALF_W + PORT_W + MSG_ID_W;

    localparam logic [LIFE_W-1:0] HOLD_RESET = 16'd6000;

    // Item operations
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RECORD   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Result outcomes
    localparam logic [OUTCOME_W-1:0] OUT_NOT_SEEN = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ANSWERED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_RECORDED = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 2'd3;

    typedef struct packed {
        logic [ADDR_HALF_W-1:0] addr_high;
        logic [ADDR_HALF_W-1:0] addr_low;
        logic [PORT_W-1:0]      src_port;
        logic [MSG_ID_W-1:0]    msg_id;
    } key_t;

endpackage

`default_nettype wire

/* rtl/ardt_key_mem.sv */
// Key store: one synchronous memory holding address, port and message id per slot.
`timescale 1ns / 1ps
`default_nettype none

module ardt_key_mem
    import ardt_pkg::*;
#(
    parameter int ENTRIES = 8,
    parameter int AW      = 3
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire key_t          wkey,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output key_t               rkey
);

    key_t mem [0:ENTRIES-1];
    key_t rkey_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wkey;
        end
        if (re)
        begin
            rkey_reg <= mem[raddr];
        end
    end

    assign rkey = rkey_reg;

endmodule

`default_nettype wire

/* rtl/ardt_life_mem.sv */
// Lifetime store: synchronous memory plus per-slot written flags that read unwritten slots as zero.
`timescale 1ns / 1ps
`default_nettype none

module ardt_life_mem
    import ardt_pkg::*;
#(
    parameter int ENTRIES = 8,
    parameter int AW      = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [LIFE_W-1:0] wlife,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [LIFE_W-1:0] rlife
);

    logic [LIFE_W-1:0]  mem [0:ENTRIES-1];
    logic [ENTRIES-1:0] written_reg;
    logic               rwritten_reg;
    logic [LIFE_W-1:0]  rdata_reg;

    // Written flags: reset clears them so every slot starts expired
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rwritten_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                written_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rwritten_reg <= written_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wlife;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rlife = rwritten_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

/* rtl/answered_request_dedup_table_top.sv */
// Top level of the answered-request deduplication table: stream ports and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Deduplication table for answered requests. Each slot holds a request key
// (128-bit source address, 16-bit source port, 16-bit message id) and a
// remaining lifetime; a slot is live while its lifetime is nonzero. Input
// beats carry the operation in s_axis_tuser: tick counts every live lifetime
// down by one and returns nothing, check reports the lowest live slot whose
// key matches (or not seen), record writes the key into the lowest expired
// slot with lifetime hold_ticks (or reports table full), and the unused code
// is dropped. Keys and lifetimes live in two synchronous memories read one
// slot per cycle; a check or record stops early on a hit or free slot. One
// item is worked at a time; a finished result waits in the output register
// and the next item is accepted meanwhile. Lifetimes reset to zero at once
// through per-slot flags, so no clearing pass follows reset. hold_ticks is
// written through hold_ticks_we / hold_ticks_wdata while idle; the user
// must keep to this, as the block itself does not enforce it.
module answered_request_dedup_table_top
    import ardt_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         hold_ticks_we,
    input  wire logic [15:0]  hold_ticks_wdata,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] addr_high, [127:64] addr_low, [143:128] src_port, [159:144] msg_id
    input  wire logic [159:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] outcome, [7:2] slot
    output logic [7:0]        m_axis_tdata
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [AW-1:0]        ev_idx_reg;
    logic [LIFE_W-1:0]    hold_reg;
    logic [OP_W-1:0]      op_reg;
    key_t                 key_reg;
    logic [OUTCOME_W-1:0] res_outcome_reg, res_outcome_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_data_reg, m_data_next;

    logic              in_accept;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    key_t              ev_key;
    logic [LIFE_W-1:0] ev_life;
    logic              ev_live;
    logic              ev_match;
    logic              ev_last;
    logic              key_we;
    logic              life_we;
    logic [LIFE_W-1:0] life_wdata;
    key_t              in_key;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_key.addr_high = s_axis_tdata[63:0];
    assign in_key.addr_low  = s_axis_tdata[127:64];
    assign in_key.src_port  = s_axis_tdata[143:128];
    assign in_key.msg_id    = s_axis_tdata[159:144];

    // Issue one slot read per scan cycle until every slot has been read
    assign rd_en   = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr = rd_cnt_reg[AW-1:0];

    // Evaluate the slot whose data returned this cycle
    assign ev_live  = (ev_life != '0);
    assign ev_match = ev_live && (ev_key == key_reg);
    assign ev_last  = (ev_idx_reg == AW'(ENTRIES - 1));

    // Writes go to the slot under evaluation while the read port has moved on
    // to the next slot, so a read and a write never meet on one slot. A
    // record ends the scan on its write, so the next item reads after it.
    ardt_key_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_key_mem (
        .clk   (clk),
        .we    (key_we),
        .waddr (ev_idx_reg),
        .wkey  (key_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rkey  (ev_key)
    );

    ardt_life_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_life_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (life_we),
        .waddr (ev_idx_reg),
        .wlife (life_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rlife (ev_life)
    );

    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        ev_valid_next    = ev_valid_reg;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        key_we           = 1'b0;
        life_we          = 1'b0;
        life_wdata       = ev_life - LIFE_W'(1);
        // Drop the output beat once taken
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // The unused operation is dropped without a scan
                if (in_accept && (s_axis_tuser != OP_RESERVED))
                begin
                    state_next    = ST_SCAN;
                    rd_cnt_next   = '0;
                    ev_valid_next = 1'b0;
                end
            end

            ST_SCAN:
            begin
                ev_valid_next = rd_en;
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (ev_valid_reg)
                begin
                    case (op_reg)
                        OP_TICK:
                        begin
                            life_we = ev_live;
                            if (ev_last)
                            begin
                                state_next    = ST_IDLE;
                                ev_valid_next = 1'b0;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (ev_match)
                            begin
                                res_outcome_next = OUT_ANSWERED;
                                res_slot_next    = SLOT_W'(ev_idx_reg);
                                state_next       = ST_DONE;
                                ev_valid_next    = 1'b0;
                            end
                            else if (ev_last)
                            begin
                                res_outcome_next = OUT_NOT_SEEN;
                                res_slot_next    = '0;
                                state_next       = ST_DONE;
                                ev_valid_next    = 1'b0;
                            end
                        end
                        OP_RECORD:
                        begin
                            if (!ev_live)
                            begin
                                key_we           = 1'b1;
                                life_we          = 1'b1;
                                life_wdata       = hold_reg;
                                res_outcome_next = OUT_RECORDED;
                                res_slot_next    = SLOT_W'(ev_idx_reg);
                                state_next       = ST_DONE;
                                ev_valid_next    = 1'b0;
                            end
                            else if (ev_last)
                            begin
                                res_outcome_next = OUT_FULL;
                                res_slot_next    = '0;
                                state_next       = ST_DONE;
                                ev_valid_next    = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next    = ST_IDLE;
                            ev_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_slot_reg, res_outcome_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next    = ST_IDLE;
                ev_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            ev_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hold_reg     <= HOLD_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            ev_valid_reg <= ev_valid_next;
            m_valid_reg  <= m_valid_next;
            if (hold_ticks_we)
            begin
                hold_reg <= hold_ticks_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= s_axis_tuser;
            key_reg <= in_key;
        end
        ev_idx_reg      <= rd_addr;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        m_data_reg      <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/ardt_checker.sv */
// Port-level checks for the deduplication table and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ardt_checker
    import ardt_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [7:0]   m_axis_tdata
);

    // A result beat stays up until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped before taken");

    // A check or record beat starts a scan that holds off the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == OP_CHECK || s_axis_tuser == OP_RECORD)
        |=> !s_axis_tready)
        else $error("input accepted during a scan");

    // The unused operation is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RESERVED)
        |=> s_axis_tready)
        else $error("unused operation stalled the input");

    // Slot is zero when no slot applies and within the table otherwise
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (((m_axis_tdata[1:0] == OUT_NOT_SEEN || m_axis_tdata[1:0] == OUT_FULL) &&
          m_axis_tdata[7:2] == '0) ||
         ((m_axis_tdata[1:0] == OUT_ANSWERED || m_axis_tdata[1:0] == OUT_RECORDED) &&
          32'(m_axis_tdata[7:2]) < ENTRIES)))
        else $error("result slot out of range");

endmodule

bind answered_request_dedup_table_top ardt_checker #(
    .ENTRIES (ENTRIES)
) u_ardt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the answered-request deduplication table.
`timescale 1ns / 1ps

module testbench;

    import ardt_pkg::*;

    localparam int ENTRIES        = 8;
    localparam int POOL_SIZE      = 12;
    // Idle wait before a register write, long enough for any scan to finish.
    localparam int SETTLE_CYCLES  = 2 * (ENTRIES + 3);
    localparam int SINK_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 270;

    typedef struct {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
    } verdict_t;

    logic         clk;
    logic         rst_n;
    logic         hold_ticks_we;
    logic [15:0]  hold_ticks_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    // Shadow copy of the table: keys, remaining lifetimes and the hold time.
    key_t              slot_key  [ENTRIES];
    logic [LIFE_W-1:0] slot_life [ENTRIES];
    logic [LIFE_W-1:0] shadow_hold;

    // Verdicts predicted for accepted beats, oldest first.
    verdict_t verdicts_due[$];

    key_t key_pool [POOL_SIZE];

    bit gaps_on;
    bit sink_hold_req;

    int errors;
    int beats_sent;
    int results_seen;
    int n_not_seen;
    int n_answered;
    int n_recorded;
    int n_full;

    answered_request_dedup_table_top #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .hold_ticks_we    (hold_ticks_we),
        .hold_ticks_wdata (hold_ticks_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Apply one request to the shadow table and queue the verdict it yields.
    function automatic void dedup_lookup(input logic [OP_W-1:0] op, input key_t key);
        verdict_t v;
        bit       done;
        done = 1'b0;
        case (op)
            OP_TICK:
            begin
                for (int k = 0; k < ENTRIES; k++)
                    if (slot_life[k] != '0)
                        slot_life[k] = slot_life[k] - 1'b1;
            end
            OP_CHECK:
            begin
                // Lowest live slot with an equal key wins.
                for (int k = 0; k < ENTRIES && !done; k++)
                begin
                    if (slot_life[k] != '0 && slot_key[k] == key)
                    begin
                        v.outcome = OUT_ANSWERED;
                        v.slot    = SLOT_W'(k);
                        done      = 1'b1;
                    end
                end
                if (!done)
                begin
                    v.outcome = OUT_NOT_SEEN;
                    v.slot    = '0;
                end
                verdicts_due.push_back(v);
            end
            OP_RECORD:
            begin
                // No duplicate check: take the lowest expired slot.
                for (int k = 0; k < ENTRIES && !done; k++)
                begin
                    if (slot_life[k] == '0)
                    begin
                        slot_key[k]  = key;
                        slot_life[k] = shadow_hold;
                        v.outcome    = OUT_RECORDED;
                        v.slot       = SLOT_W'(k);
                        done         = 1'b1;
                    end
                end
                if (!done)
                begin
                    v.outcome = OUT_FULL;
                    v.slot    = '0;
                end
                verdicts_due.push_back(v);
            end
            default:
            begin
                // Unused code: drop it, the table is untouched.
            end
        endcase
        if (op == OP_CHECK || op == OP_RECORD)
        begin
            case (v.outcome)
                OUT_NOT_SEEN: n_not_seen++;
                OUT_ANSWERED: n_answered++;
                OUT_RECORDED: n_recorded++;
                default:      n_full++;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic key_t random_key();
        key_t k;
        k.addr_high = rand64();
        k.addr_low  = rand64();
        k.src_port  = 16'($urandom());
        k.msg_id    = 16'($urandom());
        return k;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OP_TICK;
        if (r < 65)
            return OP_CHECK;
        if (r < 95)
            return OP_RECORD;
        return OP_RESERVED;
    endfunction

    // Favor keys from the pool so records and checks meet; near misses probe
    // every bit of the key compare.
    function automatic key_t pick_key();
        key_t k;
        int   r;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r >= 60 && r < 75)
            k = k ^ (key_t'(1) << $urandom_range(0, KEY_W - 1));
        else if (r >= 75 && r < 88)
        begin
            case ($urandom_range(0, 3))
                0:       k.addr_high = rand64();
                1:       k.addr_low  = rand64();
                2:       k.src_port  = 16'($urandom());
                default: k.msg_id    = 16'($urandom());
            endcase
        end
        else if (r >= 88)
            k = random_key();
        return k;
    endfunction

    function automatic void refresh_pool();
        key_pool[0] = '1;
        key_pool[1] = '0;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = random_key();
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offer one request beat, hold it until accepted, then idle for a random gap if gaps are on.
    task automatic send_item(input logic [OP_W-1:0] op, input key_t key);
        int gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {key.msg_id, key.src_port, key.addr_low, key.addr_high};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        dedup_lookup(op, key);
        beats_sent++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, drain every pending verdict, then let a tick scan finish.
    task automatic wait_table_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_hold_ticks(input logic [15:0] value);
        wait_table_idle();
        @(negedge clk);
        hold_ticks_we    = 1'b1;
        hold_ticks_wdata = value;
        @(negedge clk);
        hold_ticks_we    = 1'b0;
        shadow_hold      = value;
    endtask

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                // Long hold-off: the block fills and must stall its input.
                sink_hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else
            begin
                gap = gaps_on ? pick_gap() : 0;
                if (gap == 0)
                    m_axis_tready = 1'b1;
                else
                begin
                    m_axis_tready = 1'b0;
                    repeat (gap) @(negedge clk);
                    m_axis_tready = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        logic [OUTCOME_W-1:0] got_outcome;
        logic [SLOT_W-1:0]    got_slot;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_outcome = m_axis_tdata[1:0];
            got_slot    = m_axis_tdata[7:2];
            results_seen++;
            if (verdicts_due.size() == 0)
                note_failure($sformatf("unexpected result outcome=%0d slot=%0d",
                                       got_outcome, got_slot));
            else
            begin
                want = verdicts_due.pop_front();
                if (got_outcome !== want.outcome || got_slot !== want.slot)
                    note_failure($sformatf("outcome exp %0d got %0d, slot exp %0d got %0d",
                                           want.outcome, got_outcome, want.slot, got_slot));
            end
        end
    end

    // End the run if neither side moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("answered_request_dedup_table_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Record under the reset hold time, then fill the table and overflow it.
    task automatic test_fill_and_full();
        key_t zero_key;
        zero_key = '0;
        send_item(OP_RECORD, '1);
        load_hold_ticks(16'd3);
        send_item(OP_RECORD, zero_key);
        for (int i = 2; i < ENTRIES; i++)
            send_item(OP_RECORD, random_key());
        send_item(OP_RECORD, random_key());
    endtask

    // Hits, near misses and the unused code on a full table.
    task automatic test_lookup_cases();
        key_t probe;
        send_item(OP_CHECK, '1);
        send_item(OP_CHECK, '0);
        probe = '1;
        probe.msg_id = '0;
        send_item(OP_CHECK, probe);
        probe = '1;
        probe.addr_low[0] = 1'b0;
        send_item(OP_CHECK, probe);
        send_item(OP_RESERVED, '1);
        send_item(OP_CHECK, '1);
    endtask

    // Expire the short-lived slots, then record one key twice.
    task automatic test_tick_expiry();
        key_t twin;
        twin = random_key();
        repeat (3) send_item(OP_TICK, '0);
        send_item(OP_CHECK, '0);
        send_item(OP_RECORD, twin);
        send_item(OP_RECORD, twin);
        send_item(OP_CHECK, twin);
    endtask

    // A zero hold time records an entry that is already expired.
    task automatic test_zero_hold();
        key_t ghost;
        ghost = random_key();
        load_hold_ticks(16'd0);
        send_item(OP_RECORD, ghost);
        send_item(OP_CHECK, ghost);
        send_item(OP_TICK, ghost);
    endtask

    // Random traffic under one hold time; toggle idling in stretches.
    task automatic test_random_phase(input logic [15:0] hold, input int count);
        load_hold_ticks(hold);
        refresh_pool();
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_item(pick_op(), pick_key());
        end
        gaps_on = 1'b1;
    endtask

    // Hold off the result side while requests keep coming.
    task automatic test_output_stall();
        wait_table_idle();
        refresh_pool();
        gaps_on       = 1'b0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(($urandom_range(0, 1) != 0) ? OP_CHECK : OP_RECORD, pick_key());
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : run
        rst_n            = 1'b0;
        hold_ticks_we    = 1'b0;
        hold_ticks_wdata = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = OP_TICK;
        gaps_on          = 1'b1;
        sink_hold_req    = 1'b0;
        errors           = 0;
        beats_sent       = 0;
        results_seen     = 0;
        n_not_seen       = 0;
        n_answered       = 0;
        n_recorded       = 0;
        n_full           = 0;
        shadow_hold      = HOLD_RESET;
        for (int k = 0; k < ENTRIES; k++)
        begin
            slot_key[k]  = '0;
            slot_life[k] = '0;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_fill_and_full();
        test_lookup_cases();
        test_tick_expiry();
        test_zero_hold();
        test_random_phase(16'd1, PHASE_ITEMS);
        test_random_phase(16'd5, PHASE_ITEMS);
        test_random_phase(16'd12, PHASE_ITEMS);
        test_random_phase(16'd40, PHASE_ITEMS);
        test_random_phase(16'd2, PHASE_ITEMS);
        test_output_stall();
        // Entries from here on never expire, so run this setting last.
        test_random_phase(16'hFFFF, PHASE_ITEMS);

        wait_table_idle();
        if (verdicts_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", verdicts_due.size()));

        $display("covered %0d request beats and %0d results: %0d not seen, %0d answered,",
                 beats_sent, results_seen, n_not_seen, n_answered);
        $display("%0d recorded, %0d table full; hold times 0 to 65535; %0d failures",
                 n_recorded, n_full, errors);
        if (errors == 0)
            $display("answered_request_dedup_table_top: match");
        else
            $display("answered_request_dedup_table_top: mismatch");
        $finish;
    end

endmodule

/* answered_request_dedup_table_top.f */
rtl/ardt_pkg.sv
rtl/ardt_key_mem.sv
rtl/ardt_life_mem.sv
rtl/answered_request_dedup_table_top.sv
rtl/ardt_checker.sv
sim/testbench.sv
